// ===== hw/rtl/cna_pkg.sv =====
// ----------------------------------------------------------------------------
// cna_pkg
// Shared types, widths, operation and status codes and saturation helpers
// of the complex number arithmetic unit.
// ----------------------------------------------------------------------------
package cna_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_WIDTH  = 2 * DATA_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH + 1;
    localparam int ITER_STAGES = DATA_WIDTH;
    localparam int FRONT_STAGES = 4;
    localparam int LATENCY     = FRONT_STAGES + ITER_STAGES + 1;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_MOD  = 3'd4;
    localparam logic [2:0] OP_CONJ = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic signed [PROD_WIDTH-1:0] t_prod;
    typedef logic signed [SUM_WIDTH-1:0]  t_sum;
    typedef logic [PROD_WIDTH-1:0]        t_mag;

    typedef struct packed {
        logic [2:0] kind;
        t_data      a_re;
        t_data      a_im;
        t_data      b_re;
        t_data      b_im;
    } t_req;

    typedef struct packed {
        t_data      res_re;
        t_data      res_im;
        logic [1:0] status;
    } t_rsp;

    typedef struct packed {
        logic [2:0]            op;
        logic [DATA_WIDTH-1:0] early_re;
        logic [DATA_WIDTH-1:0] early_im;
        logic                  early_ovf;
        logic                  dz;
        logic                  re_neg;
        logic                  im_neg;
        logic                  re_ovf;
        logic                  im_ovf;
        t_mag                  d;
        t_mag                  re_rem;
        t_mag                  im_rem;
        logic [DATA_WIDTH-1:0] re_low;
        logic [DATA_WIDTH-1:0] im_low;
        logic [DATA_WIDTH-1:0] re_q;
        logic [DATA_WIDTH-1:0] im_q;
        t_mag                  sq_s;
        logic [DATA_WIDTH+1:0] sq_rem;
        logic [DATA_WIDTH-1:0] sq_root;
    } t_iter;

    function automatic t_sum sext_dw(input logic [DATA_WIDTH-1:0] a);
        return t_sum'({{(SUM_WIDTH-DATA_WIDTH){a[DATA_WIDTH-1]}}, a});
    endfunction

    // {overflow, saturated value}
    function automatic logic [DATA_WIDTH:0] sat_dw(input t_sum v);
        logic [SUM_WIDTH-DATA_WIDTH:0] hi;
        logic                          ovf;
        hi  = v[SUM_WIDTH-1:DATA_WIDTH-1];
        ovf = !((&hi) || !(|hi));
        if (!ovf) begin
            return {1'b0, v[DATA_WIDTH-1:0]};
        end else if (v[SUM_WIDTH-1]) begin
            return {1'b1, SAT_MIN};
        end else begin
            return {1'b1, SAT_MAX};
        end
    endfunction

endpackage

// ===== hw/rtl/cna_front.sv =====
// ----------------------------------------------------------------------------
// cna_front
// Four front stages: products, sums, rounding of multiply and sign split of
// the divide numerators, then setup of the divide and root recurrences.
// ----------------------------------------------------------------------------
module cna_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  cna_pkg::t_req i_data,
    output logic          o_valid,
    output cna_pkg::t_iter o_st
);

    cna_pkg::t_data  w_ar, w_ai, w_br, w_bi, w_x, w_y;
    logic [cna_pkg::DATA_WIDTH:0] w_sre, w_sim;

    cna_pkg::t_prod  n1_p0, n1_p1, n1_p2, n1_p3, n1_p4, n1_p5;
    logic            r1_valid;
    logic [2:0]      r1_op;
    cna_pkg::t_prod  r1_p0, r1_p1, r1_p2, r1_p3, r1_p4, r1_p5;
    logic [cna_pkg::DATA_WIDTH-1:0] r1_early_re, r1_early_im;
    logic            r1_early_ovf;

    logic            r2_valid;
    logic [2:0]      r2_op;
    cna_pkg::t_sum   r2_mre, r2_mim, r2_dre, r2_dim;
    cna_pkg::t_mag   r2_d;
    logic [cna_pkg::DATA_WIDTH-1:0] r2_early_re, r2_early_im;
    logic            r2_early_ovf;

    cna_pkg::t_sum   w_mre_sh, w_mim_sh;
    logic [cna_pkg::DATA_WIDTH:0] w_mul_re, w_mul_im;
    logic [cna_pkg::DATA_WIDTH-1:0] n3_early_re, n3_early_im;
    logic            n3_early_ovf;
    logic            r3_valid;
    logic [2:0]      r3_op;
    logic [cna_pkg::DATA_WIDTH-1:0] r3_early_re, r3_early_im;
    logic            r3_early_ovf;
    logic            r3_re_neg, r3_im_neg, r3_dz;
    cna_pkg::t_mag   r3_re_mag, r3_im_mag, r3_d;

    logic [cna_pkg::PROD_WIDTH+cna_pkg::FRAC_BITS-1:0] w_nre, w_nim;
    logic [cna_pkg::PROD_WIDTH+cna_pkg::FRAC_BITS-cna_pkg::DATA_WIDTH-1:0] w_r0re, w_r0im;
    cna_pkg::t_iter  n4_st;
    logic            r4_valid;
    cna_pkg::t_iter  r4_st;

    // stage 1: products and the short operations
    always_comb begin
        w_ar  = i_data.a_re;
        w_ai  = i_data.a_im;
        w_br  = i_data.b_re;
        w_bi  = i_data.b_im;
        w_x   = (i_data.kind == cna_pkg::OP_MOD) ? w_ar : w_br;
        w_y   = (i_data.kind == cna_pkg::OP_MOD) ? w_ai : w_bi;
        n1_p0 = w_ar * w_br;
        n1_p1 = w_ai * w_bi;
        n1_p2 = w_ar * w_bi;
        n1_p3 = w_ai * w_br;
        n1_p4 = w_x * w_x;
        n1_p5 = w_y * w_y;
        case (i_data.kind)
            cna_pkg::OP_ADD: begin
                w_sre = cna_pkg::sat_dw(cna_pkg::sext_dw(w_ar) + cna_pkg::sext_dw(w_br));
                w_sim = cna_pkg::sat_dw(cna_pkg::sext_dw(w_ai) + cna_pkg::sext_dw(w_bi));
            end
            cna_pkg::OP_SUB: begin
                w_sre = cna_pkg::sat_dw(cna_pkg::sext_dw(w_ar) - cna_pkg::sext_dw(w_br));
                w_sim = cna_pkg::sat_dw(cna_pkg::sext_dw(w_ai) - cna_pkg::sext_dw(w_bi));
            end
            cna_pkg::OP_CONJ: begin
                w_sre = {1'b0, w_ar};
                w_sim = cna_pkg::sat_dw(-cna_pkg::sext_dw(w_ai));
            end
            default: begin
                w_sre = '0;
                w_sim = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
        end
        if (i_adv) begin
            r1_op        <= i_data.kind;
            r1_p0        <= n1_p0;
            r1_p1        <= n1_p1;
            r1_p2        <= n1_p2;
            r1_p3        <= n1_p3;
            r1_p4        <= n1_p4;
            r1_p5        <= n1_p5;
            r1_early_re  <= w_sre[cna_pkg::DATA_WIDTH-1:0];
            r1_early_im  <= w_sim[cna_pkg::DATA_WIDTH-1:0];
            r1_early_ovf <= w_sre[cna_pkg::DATA_WIDTH] | w_sim[cna_pkg::DATA_WIDTH];
        end
    end

    // stage 2: exact sums of products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_adv) begin
            r2_valid <= r1_valid;
        end
        if (i_adv) begin
            r2_op        <= r1_op;
            r2_mre       <= {r1_p0[cna_pkg::PROD_WIDTH-1], r1_p0}
                            - {r1_p1[cna_pkg::PROD_WIDTH-1], r1_p1};
            r2_mim       <= {r1_p2[cna_pkg::PROD_WIDTH-1], r1_p2}
                            + {r1_p3[cna_pkg::PROD_WIDTH-1], r1_p3};
            r2_dre       <= {r1_p0[cna_pkg::PROD_WIDTH-1], r1_p0}
                            + {r1_p1[cna_pkg::PROD_WIDTH-1], r1_p1};
            r2_dim       <= {r1_p3[cna_pkg::PROD_WIDTH-1], r1_p3}
                            - {r1_p2[cna_pkg::PROD_WIDTH-1], r1_p2};
            r2_d         <= cna_pkg::t_mag'(r1_p4) + cna_pkg::t_mag'(r1_p5);
            r2_early_re  <= r1_early_re;
            r2_early_im  <= r1_early_im;
            r2_early_ovf <= r1_early_ovf;
        end
    end

    // stage 3: multiply rounds toward minus infinity, divide splits sign
    always_comb begin
        w_mre_sh = r2_mre >>> cna_pkg::FRAC_BITS;
        w_mim_sh = r2_mim >>> cna_pkg::FRAC_BITS;
        w_mul_re = cna_pkg::sat_dw(w_mre_sh);
        w_mul_im = cna_pkg::sat_dw(w_mim_sh);
        if (r2_op == cna_pkg::OP_MUL) begin
            n3_early_re  = w_mul_re[cna_pkg::DATA_WIDTH-1:0];
            n3_early_im  = w_mul_im[cna_pkg::DATA_WIDTH-1:0];
            n3_early_ovf = w_mul_re[cna_pkg::DATA_WIDTH] | w_mul_im[cna_pkg::DATA_WIDTH];
        end else begin
            n3_early_re  = r2_early_re;
            n3_early_im  = r2_early_im;
            n3_early_ovf = r2_early_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_adv) begin
            r3_valid <= r2_valid;
        end
        if (i_adv) begin
            r3_op        <= r2_op;
            r3_early_re  <= n3_early_re;
            r3_early_im  <= n3_early_im;
            r3_early_ovf <= n3_early_ovf;
            r3_re_neg    <= r2_dre[cna_pkg::SUM_WIDTH-1];
            r3_im_neg    <= r2_dim[cna_pkg::SUM_WIDTH-1];
            r3_re_mag    <= r2_dre[cna_pkg::SUM_WIDTH-1] ? cna_pkg::t_mag'(-r2_dre)
                                                         : cna_pkg::t_mag'(r2_dre);
            r3_im_mag    <= r2_dim[cna_pkg::SUM_WIDTH-1] ? cna_pkg::t_mag'(-r2_dim)
                                                         : cna_pkg::t_mag'(r2_dim);
            r3_d         <= r2_d;
            r3_dz        <= (r2_d == '0);
        end
    end

    // stage 4: recurrence setup, quotient too wide when the top part reaches d
    always_comb begin
        w_nre = {r3_re_mag, {cna_pkg::FRAC_BITS{1'b0}}};
        w_nim = {r3_im_mag, {cna_pkg::FRAC_BITS{1'b0}}};
        w_r0re = w_nre[cna_pkg::PROD_WIDTH+cna_pkg::FRAC_BITS-1:cna_pkg::DATA_WIDTH];
        w_r0im = w_nim[cna_pkg::PROD_WIDTH+cna_pkg::FRAC_BITS-1:cna_pkg::DATA_WIDTH];
        n4_st.op        = r3_op;
        n4_st.early_re  = r3_early_re;
        n4_st.early_im  = r3_early_im;
        n4_st.early_ovf = r3_early_ovf;
        n4_st.dz        = r3_dz;
        n4_st.re_neg    = r3_re_neg;
        n4_st.im_neg    = r3_im_neg;
        n4_st.re_ovf    = cna_pkg::t_mag'(w_r0re) >= r3_d;
        n4_st.im_ovf    = cna_pkg::t_mag'(w_r0im) >= r3_d;
        n4_st.d         = r3_d;
        n4_st.re_rem    = cna_pkg::t_mag'(w_r0re);
        n4_st.im_rem    = cna_pkg::t_mag'(w_r0im);
        n4_st.re_low    = w_nre[cna_pkg::DATA_WIDTH-1:0];
        n4_st.im_low    = w_nim[cna_pkg::DATA_WIDTH-1:0];
        n4_st.re_q      = '0;
        n4_st.im_q      = '0;
        n4_st.sq_s      = r3_d;
        n4_st.sq_rem    = '0;
        n4_st.sq_root   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_adv) begin
            r4_valid <= r3_valid;
        end
        if (i_adv) begin
            r4_st <= n4_st;
        end
    end

    assign o_valid = r4_valid;
    assign o_st    = r4_st;

endmodule

// ===== hw/rtl/cna_iter_stage.sv =====
// ----------------------------------------------------------------------------
// cna_iter_stage
// One registered step of the two restoring dividers and the digit-by-digit
// square root; one quotient bit each and one root bit per stage.
// ----------------------------------------------------------------------------
module cna_iter_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  cna_pkg::t_iter i_st,
    output logic           o_valid,
    output cna_pkg::t_iter o_st
);

    logic [cna_pkg::PROD_WIDTH:0]   w_re_step, w_im_step;
    logic [cna_pkg::DATA_WIDTH+3:0] w_sr, w_trial;
    logic [cna_pkg::DATA_WIDTH+4:0] w_sdiff;
    logic                           w_sge;
    cna_pkg::t_iter                 n_st;
    logic                           r_valid;
    cna_pkg::t_iter                 r_st;

    // {quotient bit, new remainder}
    function automatic logic [cna_pkg::PROD_WIDTH:0] div_step(
        input cna_pkg::t_mag rem, input logic bit_in, input cna_pkg::t_mag d);
        logic [cna_pkg::PROD_WIDTH:0]   rr;
        logic [cna_pkg::PROD_WIDTH+1:0] diff;
        rr   = {rem, bit_in};
        diff = {1'b0, rr} - {2'b00, d};
        if (!diff[cna_pkg::PROD_WIDTH+1]) begin
            return {1'b1, diff[cna_pkg::PROD_WIDTH-1:0]};
        end else begin
            return {1'b0, rr[cna_pkg::PROD_WIDTH-1:0]};
        end
    endfunction

    always_comb begin
        w_re_step = div_step(i_st.re_rem, i_st.re_low[cna_pkg::DATA_WIDTH-1], i_st.d);
        w_im_step = div_step(i_st.im_rem, i_st.im_low[cna_pkg::DATA_WIDTH-1], i_st.d);
        w_sr      = {i_st.sq_rem, i_st.sq_s[cna_pkg::PROD_WIDTH-1 -: 2]};
        w_trial   = {2'b00, i_st.sq_root, 2'b01};
        w_sdiff   = {1'b0, w_sr} - {1'b0, w_trial};
        w_sge     = !w_sdiff[cna_pkg::DATA_WIDTH+4];

        n_st        = i_st;
        n_st.re_rem = w_re_step[cna_pkg::PROD_WIDTH-1:0];
        n_st.im_rem = w_im_step[cna_pkg::PROD_WIDTH-1:0];
        n_st.re_q   = {i_st.re_q[cna_pkg::DATA_WIDTH-2:0], w_re_step[cna_pkg::PROD_WIDTH]};
        n_st.im_q   = {i_st.im_q[cna_pkg::DATA_WIDTH-2:0], w_im_step[cna_pkg::PROD_WIDTH]};
        n_st.re_low = {i_st.re_low[cna_pkg::DATA_WIDTH-2:0], 1'b0};
        n_st.im_low = {i_st.im_low[cna_pkg::DATA_WIDTH-2:0], 1'b0};
        n_st.sq_s   = {i_st.sq_s[cna_pkg::PROD_WIDTH-3:0], 2'b00};
        n_st.sq_rem = w_sge ? w_sdiff[cna_pkg::DATA_WIDTH+1:0] : w_sr[cna_pkg::DATA_WIDTH+1:0];
        n_st.sq_root = {i_st.sq_root[cna_pkg::DATA_WIDTH-2:0], w_sge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_valid;
    assign o_st    = r_st;

endmodule

// ===== hw/rtl/cna_back.sv =====
// ----------------------------------------------------------------------------
// cna_back
// Output stage: sign and saturation of quotients and root, result select
// and status, held in the output register.
// ----------------------------------------------------------------------------
module cna_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  cna_pkg::t_iter i_st,
    output logic           o_valid,
    output cna_pkg::t_rsp  o_data
);

    logic [cna_pkg::DATA_WIDTH:0] w_dre, w_dim;
    cna_pkg::t_rsp                n_rsp;
    logic                         r_valid;
    cna_pkg::t_rsp                r_rsp;

    // {overflow, value}
    function automatic logic [cna_pkg::DATA_WIDTH:0] div_fin(
        input logic neg, input logic ovf, input logic [cna_pkg::DATA_WIDTH-1:0] q);
        logic sat;
        if (neg) begin
            sat = ovf | (q[cna_pkg::DATA_WIDTH-1] & (|q[cna_pkg::DATA_WIDTH-2:0]));
            return sat ? {1'b1, cna_pkg::SAT_MIN} : {1'b0, -q};
        end else begin
            sat = ovf | q[cna_pkg::DATA_WIDTH-1];
            return sat ? {1'b1, cna_pkg::SAT_MAX} : {1'b0, q};
        end
    endfunction

    always_comb begin
        w_dre = div_fin(i_st.re_neg, i_st.re_ovf, i_st.re_q);
        w_dim = div_fin(i_st.im_neg, i_st.im_ovf, i_st.im_q);
        case (i_st.op)
            cna_pkg::OP_DIV: begin
                if (i_st.dz) begin
                    n_rsp.res_re = '0;
                    n_rsp.res_im = '0;
                    n_rsp.status = cna_pkg::ST_DIV0;
                end else begin
                    n_rsp.res_re = w_dre[cna_pkg::DATA_WIDTH-1:0];
                    n_rsp.res_im = w_dim[cna_pkg::DATA_WIDTH-1:0];
                    n_rsp.status = (w_dre[cna_pkg::DATA_WIDTH] | w_dim[cna_pkg::DATA_WIDTH])
                                   ? cna_pkg::ST_SAT : cna_pkg::ST_OK;
                end
            end
            cna_pkg::OP_MOD: begin
                n_rsp.res_im = '0;
                if (i_st.sq_root[cna_pkg::DATA_WIDTH-1]) begin
                    n_rsp.res_re = cna_pkg::SAT_MAX;
                    n_rsp.status = cna_pkg::ST_SAT;
                end else begin
                    n_rsp.res_re = i_st.sq_root;
                    n_rsp.status = cna_pkg::ST_OK;
                end
            end
            default: begin
                n_rsp.res_re = i_st.early_re;
                n_rsp.res_im = i_st.early_im;
                n_rsp.status = i_st.early_ovf ? cna_pkg::ST_SAT : cna_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_rsp;

endmodule

// ===== hw/rtl/complex_number_alu_top.sv =====
// ----------------------------------------------------------------------------
// complex_number_alu_top
// Complex arithmetic unit on signed Q16.16 parts: add, subtract, multiply,
// divide, modulus and conjugate, with saturation and status.
// ----------------------------------------------------------------------------
// The request channel (i_valid, i_data, o_stall) takes one operation with two
// complex operands; the response channel (o_valid, o_data, i_stall) returns
// one result with a status per request, in request order.
// The pipeline has four front stages (products, sums, rounding and
// sign split, recurrence setup), 32 stages that each make one quotient bit
// of both dividers and one root bit, and the output register.
// Throughput is one request per cycle for every operation mix unless held.
// The whole pipeline advances together; it holds only while the output
// register carries a response and i_stall is high, and then o_stall is
// raised so no request is lost or repeated.
// Reset clears all valid bits, so no request survives; data is not reset.
// ----------------------------------------------------------------------------
module complex_number_alu_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  cna_pkg::t_req i_data,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output cna_pkg::t_rsp o_data
);

    logic           w_adv;
    logic           w_vld [0:cna_pkg::ITER_STAGES];
    cna_pkg::t_iter w_st  [0:cna_pkg::ITER_STAGES];

    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    cna_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (w_vld[0]),
        .o_st    (w_st[0])
    );

    for (genvar g = 0; g < cna_pkg::ITER_STAGES; g++) begin : g_iter
        cna_iter_stage u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_vld[g]),
            .i_st    (w_st[g]),
            .o_valid (w_vld[g+1]),
            .o_st    (w_st[g+1])
        );
    end

    cna_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_vld[cna_pkg::ITER_STAGES]),
        .i_st    (w_st[cna_pkg::ITER_STAGES]),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

`ifndef NO_ASSERTIONS
    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == cna_pkg::ST_DIV0
        |-> o_data.res_re == '0 && o_data.res_im == '0)
        else $error("divide by zero response with nonzero parts");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == cna_pkg::ST_SAT
        |-> o_data.res_re == cna_pkg::SAT_MAX || o_data.res_re == cna_pkg::SAT_MIN
            || o_data.res_im == cna_pkg::SAT_MAX || o_data.res_im == cna_pkg::SAT_MIN)
        else $error("saturated status without a limit value");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.status == cna_pkg::ST_OK || o_data.status == cna_pkg::ST_SAT
                    || o_data.status == cna_pkg::ST_DIV0)
        else $error("undefined status code");

    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(w_vld[0]) && $stable(w_st[0]))
        else $error("front stage moved while the output was held");
`endif

endmodule

// ===== tb/sv/complex_number_alu_top_tb.sv =====
// ----------------------------------------------------------------------------
// complex_number_alu_top_tb
// Drives random and corner-case complex operations into the arithmetic unit
// with random gaps and output stalls, predicts every response in exact
// wide arithmetic and checks each returned response in order.
// ----------------------------------------------------------------------------
module complex_number_alu_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cna_pkg::*;

    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;
    localparam t_data  DMAX = t_data'(VMAX);
    localparam t_data  DMIN = t_data'(VMIN);

    localparam logic [2:0] OP_RSVD_A = 3'd6;
    localparam logic [2:0] OP_RSVD_B = 3'd7;

    class alu_scoreboard;
        t_rsp expected_q[$];
        int   errors;

        function void sat(input longint v, inout bit ovf, output t_data r);
            if (v > VMAX) begin
                ovf = 1;
                r = t_data'(VMAX);
            end else if (v < VMIN) begin
                ovf = 1;
                r = t_data'(VMIN);
            end else begin
                r = t_data'(v);
            end
        endfunction

        function void sat_wide(input logic signed [127:0] v, inout bit ovf, output t_data r);
            if (v > 128'(VMAX)) begin
                ovf = 1;
                r = t_data'(VMAX);
            end else if (v < -128'sd2147483648) begin
                ovf = 1;
                r = t_data'(VMIN);
            end else begin
                r = t_data'(v);
            end
        endfunction

        function logic [63:0] root_floor(input logic [63:0] s);
            logic [63:0] r;
            logic [63:0] b;
            r = '0;
            b = 64'd1 << 62;
            while (b > s) b = b >> 2;
            while (b != 0) begin
                if (s >= r + b) begin
                    s = s - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function t_rsp predict(input t_req q);
            logic signed [127:0] ar, ai, br, bi, num, quo, mag, d;
            t_rsp r;
            bit ovf;
            ar = 128'(q.a_re); ai = 128'(q.a_im); br = 128'(q.b_re); bi = 128'(q.b_im);
            r = '0;
            ovf = 0;
            case (q.kind)
                OP_ADD: begin
                    sat(longint'(q.a_re) + longint'(q.b_re), ovf, r.res_re);
                    sat(longint'(q.a_im) + longint'(q.b_im), ovf, r.res_im);
                end
                OP_SUB: begin
                    sat(longint'(q.a_re) - longint'(q.b_re), ovf, r.res_re);
                    sat(longint'(q.a_im) - longint'(q.b_im), ovf, r.res_im);
                end
                OP_MUL: begin
                    sat_wide((ar * br - ai * bi) >>> FRAC_BITS, ovf, r.res_re);
                    sat_wide((ar * bi + ai * br) >>> FRAC_BITS, ovf, r.res_im);
                end
                OP_DIV: begin
                    d = br * br + bi * bi;
                    if (d == 0) begin
                        r.status = ST_DIV0;
                    end else begin
                        num = ar * br + ai * bi;
                        mag = num < 0 ? -num : num;
                        quo = (mag << FRAC_BITS) / d;
                        sat_wide(num < 0 ? -quo : quo, ovf, r.res_re);
                        num = ai * br - ar * bi;
                        mag = num < 0 ? -num : num;
                        quo = (mag << FRAC_BITS) / d;
                        sat_wide(num < 0 ? -quo : quo, ovf, r.res_im);
                    end
                end
                OP_MOD: begin
                    mag = ar * ar + ai * ai;
                    sat_wide(128'(root_floor(mag[63:0])), ovf, r.res_re);
                end
                OP_CONJ: begin
                    r.res_re = q.a_re;
                    sat(-longint'(q.a_im), ovf, r.res_im);
                end
                default: ;
            endcase
            if (r.status == ST_OK && ovf) r.status = ST_SAT;
            return r;
        endfunction

        function void note_request(input t_req q);
            expected_q.push_back(predict(q));
        endfunction

        function void check_response(input t_rsp got);
            t_rsp e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: response with none expected, actual %h", $time, got);
                return;
            end
            e = expected_q.pop_front();
            if (got.res_re !== e.res_re) begin
                errors++;
                $display("%0t: res_re expected %h actual %h", $time, e.res_re, got.res_re);
            end
            if (got.res_im !== e.res_im) begin
                errors++;
                $display("%0t: res_im expected %h actual %h", $time, e.res_im, got.res_im);
            end
            if (got.status !== e.status) begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_stall = 0;
    t_req i_data = '0;
    logic o_stall, o_valid;
    t_rsp o_data;
    alu_scoreboard board = new();
    longint cycles = 0;
    bit stall_enable = 1;

    complex_number_alu_top DUT (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_data rand_part();
        case ($urandom_range(0, 7))
            0: return t_data'(VMAX);
            1: return t_data'(VMIN);
            2: return '0;
            3: return t_data'($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            4: return t_data'($urandom_range(0, 32'h7fffff)) - 32'sh400000;
            default: return t_data'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) board.check_response(o_data);
        if (i_rst_n && i_valid && !o_stall) board.note_request(i_data);
        if (cycles > 400000) begin
            $display("complex_number_alu_top: mismatch");
            $finish;
        end
    end

    int stall_left = 0;
    always @(negedge i_clk) begin
        if (!stall_enable) begin
            i_stall <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1;
        end else begin
            stall_left <= gap_len();
            i_stall <= 0;
        end
    end

    task automatic send_request(input t_req q);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(negedge i_clk);
        end
        i_data <= q;
        i_valid <= 1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_op(input logic [2:0] k, input t_data ar, input t_data ai,
                           input t_data br, input t_data bi);
        t_req q;
        q.kind = k; q.a_re = ar; q.a_im = ai; q.b_re = br; q.b_im = bi;
        send_request(q);
    endtask

    initial begin
        t_req q;
        int idle;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        send_op(OP_ADD, DMAX, DMIN, DMAX, DMIN);
        send_op(OP_ADD, 32'sh10000, -32'sh8000, 32'sh20000, 32'sh8000);
        send_op(OP_SUB, DMIN, DMAX, 1, -1);
        send_op(OP_SUB, 32'sh30000, 5, 32'sh10000, 7);
        send_op(OP_MUL, 32'sh10000, 32'sh10000, 32'sh10000, -32'sh10000);
        send_op(OP_MUL, DMIN, DMIN, DMIN, DMIN);
        send_op(OP_MUL, -1, 0, 1, 0);
        send_op(OP_MUL, DMAX, DMAX, DMAX, DMIN);
        send_op(OP_DIV, 32'sh10000, 32'sh10000, 0, 0);
        send_op(OP_DIV, 32'sh10000, 0, 32'sh20000, 0);
        send_op(OP_DIV, -32'sh10000, 32'sh30000, 32'sh10000, 32'sh10000);
        send_op(OP_DIV, DMAX, DMIN, 1, 0);
        send_op(OP_DIV, DMIN, DMIN, DMIN, DMIN);
        send_op(OP_MOD, 32'sh30000, 32'sh40000, 5, 6);
        send_op(OP_MOD, DMIN, DMIN, 0, 0);
        send_op(OP_MOD, 0, 0, 0, 0);
        send_op(OP_MOD, DMAX, -3, 0, 0);
        send_op(OP_CONJ, 32'sh12345, DMIN, 0, 0);
        send_op(OP_CONJ, DMIN, DMAX, 0, 0);
        send_op(OP_RSVD_A, 1, 2, 3, 4);
        send_op(OP_RSVD_B, -1, -1, -1, -1);
        for (int n = 0; n < 700; n++) begin
            if ($urandom_range(0, 19) == 0) begin
                q.kind = ($urandom_range(0, 1) == 0) ? OP_RSVD_A : OP_RSVD_B;
            end else begin
                q.kind = 3'($urandom_range(0, 5));
            end
            q.a_re = rand_part();
            q.a_im = rand_part();
            q.b_re = rand_part();
            q.b_im = $urandom_range(0, 15) == 0 ? t_data'(0) : rand_part();
            if (q.kind == OP_DIV && $urandom_range(0, 9) == 0) q.b_re = '0;
            send_request(q);
            if (n == 350) begin
                i_valid <= 0;
                stall_enable = 0;
                repeat (60) @(negedge i_clk);
                stall_enable = 1;
            end
        end
        i_valid <= 0;
        while (board.expected_q.size() != 0) @(negedge i_clk);
        idle = 0;
        while (idle < LATENCY + 10) begin
            @(negedge i_clk);
            idle++;
        end
        if (board.errors == 0 && board.expected_q.size() == 0) begin
            $display("complex_number_alu_top: match");
        end else begin
            $display("complex_number_alu_top: mismatch");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/cna_pkg.sv
hw/rtl/cna_front.sv
hw/rtl/cna_iter_stage.sv
hw/rtl/cna_back.sv
hw/rtl/complex_number_alu_top.sv
tb/sv/complex_number_alu_top_tb.sv
